// ----- design/npt_pkg.sv -----
`timescale 1ns / 1ps
package npt_pkg;

	// coordinate width, Q16.16 at 32
	localparam int COORD_BITS = 32;
	localparam int CFG_BITS = 63;
	localparam int CFG_IDX_BITS = 3;
	localparam int DIST_BITS = COORD_BITS + 1;

	// internal widths
	localparam int DW = COORD_BITS + 1;       // vertex / query difference
	localparam int FW = COORD_BITS + 3;       // projected coordinate
	localparam int MB = COORD_BITS + 4;       // serial multiplier operand
	localparam int XW = 3 * COORD_BITS + 6;   // wide products and sums
	localparam int RW = 2 * COORD_BITS + 4;   // squared edge length, divider remainder
	localparam int QB = COORD_BITS + 2;       // quotient bits
	localparam int SR = COORD_BITS + 2;       // square root result bits
	localparam int SI = 2 * SR;               // square root radicand bits
	localparam int CMPW = (XW > CFG_BITS) ? XW : CFG_BITS;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_A_X = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_A_Y = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_B_X = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_B_Y = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_C_X = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_C_Y = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_TOL = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_LIM = 3'd7;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] query_x;
		logic signed [COORD_BITS-1:0] query_y;
		logic                         on_entity;
	} npt_in_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] nearest_x;
		logic signed [COORD_BITS-1:0] nearest_y;
		logic [DIST_BITS-1:0]         distance;
		logic                         inside_res;
		logic                         vertex_used;
	} npt_out_t;

endpackage

// ----- design/nearest_point_on_triangle_top.sv -----
`timescale 1ns / 1ps
// Channel   | Ports                            | Transfer
// ----------+----------------------------------+------------------------------------
// config    | cfg_we, cfg_index, cfg_data      | cfg_we high at a rising edge
// query in  | start, busy, query               | start high and busy low at an edge
// result    | done, result                     | done high for one cycle, no back-pressure
//
// One query at a time. An inside query needs only the cross product of each edge, each
// built as a difference of products; an outside query also runs the edge projections,
// the serial divider and the square root unit, and the nearest-vertex fallback
// adds three vertex distances. All products share the single bit-serial multiplier.
// busy is low only in idle; done pulses in the cycle busy drops.
// Reset (arst_n low) clears the triangle, the limits and any query in flight.
// The receiver cannot stall: a result is shown for exactly one cycle.
module nearest_point_on_triangle_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [npt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [npt_pkg::CFG_BITS-1:0]        cfg_data,
	input  logic                                start,
	input  npt_pkg::npt_in_t                    query,
	output logic                                busy,
	output logic                                done,
	output npt_pkg::npt_out_t                   result
);
	import npt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CR_A, S_CR_B, S_CR_CHK, S_DECIDE,
		S_LEN_A, S_LEN_B, S_LEN_CHK, S_DOT_A, S_DOT_B,
		S_NUM_X, S_DIV_X, S_NUM_Y, S_DIV_Y,
		S_DST_A, S_DST_B, S_DST_CMP, S_VTX_LD, S_BOX, S_SQRT
	} state_t;

	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [FW-1:0] v);
		logic signed [FW-1:0] hi;
		logic signed [FW-1:0] lo;
		hi = {{(FW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
		lo = ~hi;
		if (v > hi)
			return hi[COORD_BITS-1:0];
		else if (v < lo)
			return lo[COORD_BITS-1:0];
		else
			return v[COORD_BITS-1:0];
	endfunction

	// triangle and limits
	logic signed [COORD_BITS-1:0] vx_q [3];
	logic signed [COORD_BITS-1:0] vy_q [3];
	logic [CFG_BITS-1:0]          tol_q;
	logic [CFG_BITS-1:0]          lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
			end
			tol_q <= '0;
			lim_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_A_X:       vx_q[0] <= cfg_data[COORD_BITS-1:0];
				REG_A_Y:       vy_q[0] <= cfg_data[COORD_BITS-1:0];
				REG_B_X:       vx_q[1] <= cfg_data[COORD_BITS-1:0];
				REG_B_Y:       vy_q[1] <= cfg_data[COORD_BITS-1:0];
				REG_C_X:       vx_q[2] <= cfg_data[COORD_BITS-1:0];
				REG_C_Y:       vy_q[2] <= cfg_data[COORD_BITS-1:0];
				REG_SIDE_TOL:  tol_q <= cfg_data;
				REG_SHORT_LIM: lim_q <= cfg_data;
			endcase
		end
	end

	state_t state_q;
	logic   issued_q;
	logic [1:0] e_q;          // edge index, or vertex index in the fallback pass
	logic [1:0] e_nx;
	logic   neg_q, pos_q, vtx_q, vu_q, on_q;
	logic signed [COORD_BITS-1:0] qx_q, qy_q;
	logic signed [XW-1:0] acc_q, dot_q;
	logic [RW-1:0]        len_q;
	logic signed [FW-1:0] fx_q, fy_q, bx_q, by_q;
	logic [XW-1:0]        best_q;
	logic                 done_q;
	npt_out_t             res_q;

	assign e_nx = (e_q == 2'd2) ? 2'd0 : e_q + 2'd1;

	// edge vectors and offsets from the edge start
	logic signed [DW-1:0] ex, ey, wx, wy;
	logic signed [MB-1:0] fdx, fdy;
	assign ex  = DW'(vx_q[e_nx]) - DW'(vx_q[e_q]);
	assign ey  = DW'(vy_q[e_nx]) - DW'(vy_q[e_q]);
	assign wx  = DW'(qx_q) - DW'(vx_q[e_q]);
	assign wy  = DW'(qy_q) - DW'(vy_q[e_q]);
	assign fdx = MB'(fx_q) - MB'(qx_q);
	assign fdy = MB'(fy_q) - MB'(qy_q);

	// shared units
	logic mul_st, mul_go, mul_done;
	logic div_go, div_done, sqrt_go, sqrt_done;
	logic signed [XW-1:0] mul_a, mul_p;
	logic signed [MB-1:0] mul_b;
	logic signed [FW-1:0] div_quo;
	logic [DIST_BITS-1:0] sqrt_root;

	assign mul_st = (state_q == S_CR_A) || (state_q == S_CR_B) || (state_q == S_LEN_A) ||
		(state_q == S_LEN_B) || (state_q == S_DOT_A) || (state_q == S_DOT_B) ||
		(state_q == S_NUM_X) || (state_q == S_NUM_Y) || (state_q == S_DST_A) ||
		(state_q == S_DST_B);
	assign mul_go  = mul_st && !issued_q;
	assign div_go  = ((state_q == S_DIV_X) || (state_q == S_DIV_Y)) && !issued_q;
	assign sqrt_go = (state_q == S_SQRT) && !issued_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_CR_A:  begin mul_a = XW'(ex);  mul_b = MB'(wy); end
			S_CR_B:  begin mul_a = XW'(ey);  mul_b = MB'(wx); end
			S_LEN_A: begin mul_a = XW'(ex);  mul_b = MB'(ex); end
			S_LEN_B: begin mul_a = XW'(ey);  mul_b = MB'(ey); end
			S_DOT_A: begin mul_a = XW'(wx);  mul_b = MB'(ex); end
			S_DOT_B: begin mul_a = XW'(wy);  mul_b = MB'(ey); end
			S_NUM_X: begin mul_a = dot_q;    mul_b = MB'(ex); end
			S_NUM_Y: begin mul_a = dot_q;    mul_b = MB'(ey); end
			S_DST_A: begin mul_a = XW'(fdx); mul_b = fdx; end
			S_DST_B: begin mul_a = XW'(fdy); mul_b = fdy; end
			default: ;
		endcase
	end

	npt_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	npt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (acc_q),
		.den    (len_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	npt_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sqrt_go),
		.rad    (best_q[SI-1:0]),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// decisions
	logic signed [XW-1:0] acc_sum, acc_dif;
	logic [XW-1:0]        cmag, d2u;
	logic                 c_over, deg, in_box;
	logic signed [COORD_BITS-1:0] mnx, mxx, mny, mxy;

	assign acc_sum = acc_q + mul_p;
	assign acc_dif = acc_q - mul_p;
	assign cmag    = acc_q[XW-1] ? XW'(-acc_q) : XW'(acc_q);
	assign c_over  = CMPW'(cmag) > CMPW'(tol_q);
	assign deg     = (len_q == '0) || (CMPW'(len_q) < CMPW'(lim_q));
	assign d2u     = acc_q;

	always_comb begin
		mnx = vx_q[0];
		mxx = vx_q[0];
		mny = vy_q[0];
		mxy = vy_q[0];
		for (int i = 1; i < 3; i++) begin
			if (vx_q[i] < mnx) mnx = vx_q[i];
			if (vx_q[i] > mxx) mxx = vx_q[i];
			if (vy_q[i] < mny) mny = vy_q[i];
			if (vy_q[i] > mxy) mxy = vy_q[i];
		end
	end

	assign in_box = (bx_q >= FW'(mnx)) && (bx_q <= FW'(mxx)) &&
		(by_q >= FW'(mny)) && (by_q <= FW'(mxy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
			e_q      <= '0;
			neg_q    <= 1'b0;
			pos_q    <= 1'b0;
			vtx_q    <= 1'b0;
			vu_q     <= 1'b0;
			on_q     <= 1'b0;
			qx_q     <= '0;
			qy_q     <= '0;
			acc_q    <= '0;
			dot_q    <= '0;
			len_q    <= '0;
			fx_q     <= '0;
			fy_q     <= '0;
			bx_q     <= '0;
			by_q     <= '0;
			best_q   <= '0;
			done_q   <= 1'b0;
			res_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (mul_go || div_go || sqrt_go)
				issued_q <= 1'b1;
			else if (mul_done || div_done || sqrt_done)
				issued_q <= 1'b0;

			unique case (state_q)
				S_IDLE: if (start) begin
					qx_q    <= query.query_x;
					qy_q    <= query.query_y;
					on_q    <= query.on_entity;
					e_q     <= '0;
					neg_q   <= 1'b0;
					pos_q   <= 1'b0;
					vtx_q   <= 1'b0;
					vu_q    <= 1'b0;
					state_q <= S_CR_A;
				end
				S_CR_A: if (mul_done) begin
					acc_q   <= mul_p;
					state_q <= S_CR_B;
				end
				S_CR_B: if (mul_done) begin
					acc_q   <= acc_dif;
					state_q <= S_CR_CHK;
				end
				S_CR_CHK: begin
					if (c_over) begin
						if (acc_q[XW-1])
							neg_q <= 1'b1;
						else
							pos_q <= 1'b1;
					end
					if (e_q == 2'd2) begin
						state_q <= S_DECIDE;
					end else begin
						e_q     <= e_nx;
						state_q <= S_CR_A;
					end
				end
				S_DECIDE: begin
					if (!(neg_q && pos_q)) begin
						// inside, or a flat triangle: the point itself
						res_q.nearest_x   <= qx_q;
						res_q.nearest_y   <= qy_q;
						res_q.distance    <= '0;
						res_q.inside_res  <= 1'b1;
						res_q.vertex_used <= 1'b0;
						done_q            <= 1'b1;
						state_q           <= S_IDLE;
					end else begin
						e_q     <= '0;
						state_q <= S_LEN_A;
					end
				end
				S_LEN_A: if (mul_done) begin
					acc_q   <= mul_p;
					state_q <= S_LEN_B;
				end
				S_LEN_B: if (mul_done) begin
					len_q   <= acc_sum[RW-1:0];
					state_q <= S_LEN_CHK;
				end
				S_LEN_CHK: begin
					if (deg) begin
						// short edge: its start vertex stands in
						fx_q    <= FW'(vx_q[e_q]);
						fy_q    <= FW'(vy_q[e_q]);
						state_q <= S_DST_A;
					end else begin
						state_q <= S_DOT_A;
					end
				end
				S_DOT_A: if (mul_done) begin
					acc_q   <= mul_p;
					state_q <= S_DOT_B;
				end
				S_DOT_B: if (mul_done) begin
					dot_q   <= acc_sum;
					state_q <= S_NUM_X;
				end
				S_NUM_X: if (mul_done) begin
					acc_q   <= mul_p;
					state_q <= S_DIV_X;
				end
				S_DIV_X: if (div_done) begin
					fx_q    <= FW'(vx_q[e_q]) + div_quo;
					state_q <= S_NUM_Y;
				end
				S_NUM_Y: if (mul_done) begin
					acc_q   <= mul_p;
					state_q <= S_DIV_Y;
				end
				S_DIV_Y: if (div_done) begin
					fy_q    <= FW'(vy_q[e_q]) + div_quo;
					state_q <= S_DST_A;
				end
				S_DST_A: if (mul_done) begin
					acc_q   <= mul_p;
					state_q <= S_DST_B;
				end
				S_DST_B: if (mul_done) begin
					acc_q   <= acc_sum;
					state_q <= S_DST_CMP;
				end
				S_DST_CMP: begin
					// first candidate always taken; ties keep the earlier one
					if ((e_q == 2'd0) || (d2u < best_q)) begin
						best_q <= d2u;
						bx_q   <= fx_q;
						by_q   <= fy_q;
					end
					if (e_q == 2'd2) begin
						state_q <= vtx_q ? S_SQRT : S_BOX;
					end else begin
						e_q     <= e_nx;
						state_q <= vtx_q ? S_VTX_LD : S_LEN_A;
					end
				end
				S_VTX_LD: begin
					fx_q    <= FW'(vx_q[e_q]);
					fy_q    <= FW'(vy_q[e_q]);
					state_q <= S_DST_A;
				end
				S_BOX: begin
					if (on_q && !in_box) begin
						vu_q    <= 1'b1;
						vtx_q   <= 1'b1;
						e_q     <= '0;
						state_q <= S_VTX_LD;
					end else begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: if (sqrt_done) begin
					res_q.nearest_x   <= sat_coord(bx_q);
					res_q.nearest_y   <= sat_coord(by_q);
					res_q.distance    <= sqrt_root;
					res_q.inside_res  <= 1'b0;
					res_q.vertex_used <= vu_q;
					done_q            <= 1'b1;
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result transfer while busy");
	a_inside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.inside_res |-> (result.distance == '0) && !result.vertex_used)
		else $error("inside result with distance or fallback");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted query did not start");
	a_unit_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done || div_done || sqrt_done |-> issued_q)
		else $error("unit finished without an issue");

endmodule

// ----- design/npt_mul.sv -----
`timescale 1ns / 1ps
// Bit-serial signed multiplier: one multiplier bit per cycle, MSB first.
module npt_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic signed [npt_pkg::XW-1:0] a,
	input  logic signed [npt_pkg::MB-1:0] b,
	output logic                          done,
	output logic signed [npt_pkg::XW-1:0] p
);
	import npt_pkg::*;

	localparam int CW = $clog2(MB + 1);

	logic [XW-1:0] mc_q;
	logic [XW-1:0] acc_q;
	logic [MB-1:0] mp_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          run_q;
	logic          done_q;
	logic signed [XW-1:0] p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q   <= '0;
			acc_q  <= '0;
			mp_q   <= '0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			p_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				mc_q  <= a[XW-1] ? XW'(-a) : XW'(a);
				mp_q  <= b[MB-1] ? MB'(-b) : MB'(b);
				neg_q <= a[XW-1] ^ b[MB-1];
				acc_q <= '0;
				cnt_q <= CW'(MB);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (cnt_q != '0) begin
					acc_q <= (acc_q << 1) + (mp_q[MB-1] ? mc_q : '0);
					mp_q  <= mp_q << 1;
					cnt_q <= cnt_q - 1'b1;
				end else begin
					p_q    <= neg_q ? -$signed(acc_q) : $signed(acc_q);
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

// ----- design/npt_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, rounds halves away from zero.
// Quotient magnitude is known to fit QB bits.
module npt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic signed [npt_pkg::XW-1:0] num,
	input  logic [npt_pkg::RW-1:0]        den,
	output logic                          done,
	output logic signed [npt_pkg::FW-1:0] quo
);
	import npt_pkg::*;

	localparam int CW = $clog2(QB + 1);

	logic [XW-1:0] mag;
	logic [RW-1:0] rem_q;
	logic [QB-1:0] nl_q;
	logic [QB-1:0] q_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          run_q;
	logic          done_q;
	logic signed [FW-1:0] quo_q;
	logic [RW:0]   trial;
	logic          fits;
	logic [QB:0]   qr;

	assign mag   = num[XW-1] ? XW'(-num) : XW'(num);
	assign trial = {rem_q, nl_q[QB-1]};
	assign fits  = trial >= {1'b0, den};
	assign qr    = (QB+1)'(q_q) + (QB+1)'({rem_q, 1'b0} >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			nl_q   <= '0;
			q_q    <= '0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				rem_q <= RW'(mag >> QB);
				nl_q  <= mag[QB-1:0];
				q_q   <= '0;
				neg_q <= num[XW-1];
				cnt_q <= CW'(QB);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (cnt_q != '0) begin
					rem_q <= fits ? RW'(trial - {1'b0, den}) : RW'(trial);
					q_q   <= {q_q[QB-2:0], fits};
					nl_q  <= nl_q << 1;
					cnt_q <= cnt_q - 1'b1;
				end else begin
					quo_q  <= neg_q ? -$signed(FW'(qr)) : $signed(FW'(qr));
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- design/npt_sqrt.sv -----
`timescale 1ns / 1ps
// Digit-by-digit integer square root, two radicand bits per cycle; saturates.
module npt_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [npt_pkg::SI-1:0]         rad,
	output logic                           done,
	output logic [npt_pkg::DIST_BITS-1:0]  root
);
	import npt_pkg::*;

	localparam int CW = $clog2(SR + 1);
	localparam int SQW = SR + 4;

	logic [SI-1:0]        rad_q;
	logic [SR+1:0]        rem_q;
	logic [SR-1:0]        root_q;
	logic [CW-1:0]        cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIST_BITS-1:0] out_q;
	logic [SQW-1:0]       r2;
	logic [SQW-1:0]       trial;

	assign r2    = {rem_q, rad_q[SI-1 -: 2]};
	assign trial = SQW'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			out_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				rad_q  <= rad;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CW'(SR);
				run_q  <= 1'b1;
			end else if (run_q) begin
				if (cnt_q != '0) begin
					if (r2 >= trial) begin
						rem_q  <= (SR+2)'(r2 - trial);
						root_q <= {root_q[SR-2:0], 1'b1};
					end else begin
						rem_q  <= (SR+2)'(r2);
						root_q <= {root_q[SR-2:0], 1'b0};
					end
					rad_q <= rad_q << 2;
					cnt_q <= cnt_q - 1'b1;
				end else begin
					out_q  <= (root_q[SR-1:DIST_BITS] != '0) ? '1 : root_q[DIST_BITS-1:0];
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = out_q;

endmodule

// ----- verif/nearest_point_on_triangle_top_tb.sv -----
`timescale 1ns / 1ps
module nearest_point_on_triangle_top_tb;
	import npt_pkg::*;

	// cycles without any transfer before the run is declared hung; sender gaps are short
	localparam int HANG_LIMIT = 20000;
	localparam longint C_MAX = 64'sd2147483647;
	localparam longint C_MIN = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;
	logic start = 1'b0;
	npt_in_t query = '0;
	logic busy;
	logic done;
	npt_out_t result;

	nearest_point_on_triangle_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .query(query), .busy(busy),
		.done(done), .result(result)
	);

	// shadow of the triangle and limits
	longint tri_x[3], tri_y[3];
	logic [62:0] side_tol, edge_lim;

	npt_in_t queries_waiting[$];
	npt_out_t nearest_due[$];
	int idle_pct = 0;
	int n_fail = 0, n_sent = 0, n_seen = 0, n_inside = 0, n_vertex = 0, quiet_cycles = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic signed [127:0] smul(longint a, longint b);
		logic signed [127:0] x, y;
		x = a;
		y = b;
		return x * y;
	endfunction

	function automatic logic [127:0] sq_dist(longint ax, longint ay, longint bx, longint by);
		return smul(ax - bx, ax - bx) + smul(ay - by, ay - by);
	endfunction

	function automatic logic [31:0] clamp_coord(longint v);
		if (v > C_MAX) v = C_MAX;
		if (v < C_MIN) v = C_MIN;
		return v[31:0];
	endfunction

	// n / den rounded to nearest, halves away from zero
	function automatic longint round_quot(logic signed [127:0] n, logic [127:0] den);
		logic [127:0] mag, quo, rem;
		longint qv;
		mag = n[127] ? -n : n;
		quo = mag / den;
		rem = mag % den;
		if ((rem << 1) >= den) quo = quo + 1;
		qv = {2'b00, quo[61:0]};
		return n[127] ? -qv : qv;
	endfunction

	function automatic npt_out_t predict_nearest(npt_in_t q);
		npt_out_t r;
		longint qx, qy, ex, ey, fx, fy, bx, by, mnx, mxx, mny, mxy;
		logic signed [127:0] cr, dotp;
		logic [127:0] mag, len2, d2, best, cand, root;
		bit has_neg, has_pos, vu;
		int j;
		qx = longint'(q.query_x);
		qy = longint'(q.query_y);
		has_neg = 0;
		has_pos = 0;
		vu = 0;
		bx = 0;
		by = 0;
		best = '0;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			cr = smul(tri_x[j] - tri_x[i], qy - tri_y[i]) - smul(tri_y[j] - tri_y[i], qx - tri_x[i]);
			mag = cr[127] ? -cr : cr;
			if (mag > {65'd0, side_tol}) begin
				if (cr[127]) has_neg = 1;
				else has_pos = 1;
			end
		end
		if (!(has_neg && has_pos)) begin
			r.nearest_x = q.query_x;
			r.nearest_y = q.query_y;
			r.inside_res = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			ex = tri_x[j] - tri_x[i];
			ey = tri_y[j] - tri_y[i];
			fx = tri_x[i];
			fy = tri_y[i];
			len2 = smul(ex, ex) + smul(ey, ey);
			// short or zero-length edge: its start vertex stands in
			if (len2 != 0 && len2 >= {65'd0, edge_lim}) begin
				dotp = smul(qx - tri_x[i], ex) + smul(qy - tri_y[i], ey);
				fx = tri_x[i] + round_quot(dotp * ex, len2);
				fy = tri_y[i] + round_quot(dotp * ey, len2);
			end
			d2 = sq_dist(fx, fy, qx, qy);
			if (i == 0 || d2 < best) begin
				best = d2;
				bx = fx;
				by = fy;
			end
		end
		mnx = tri_x[0]; mxx = tri_x[0]; mny = tri_y[0]; mxy = tri_y[0];
		for (int i = 1; i < 3; i++) begin
			if (tri_x[i] < mnx) mnx = tri_x[i];
			if (tri_x[i] > mxx) mxx = tri_x[i];
			if (tri_y[i] < mny) mny = tri_y[i];
			if (tri_y[i] > mxy) mxy = tri_y[i];
		end
		if (q.on_entity && !(bx >= mnx && bx <= mxx && by >= mny && by <= mxy)) begin
			vu = 1;
			for (int i = 0; i < 3; i++) begin
				cand = sq_dist(tri_x[i], tri_y[i], qx, qy);
				if (i == 0 || cand < best) begin
					best = cand;
					bx = tri_x[i];
					by = tri_y[i];
				end
			end
		end
		root = '0;
		for (int b = 55; b >= 0; b--) begin
			cand = root | (128'd1 << b);
			if (cand * cand <= best) root = cand;
		end
		r.nearest_x = clamp_coord(bx);
		r.nearest_y = clamp_coord(by);
		r.distance = (root > 128'h1_FFFF_FFFF) ? '1 : root[32:0];
		r.vertex_used = vu;
		return r;
	endfunction

	// driver: start held until the transfer, next item only after it
	always @(posedge clk) begin
		if (start && !busy) begin
			nearest_due.push_back(predict_nearest(query));
			void'(queries_waiting.pop_front());
			n_sent++;
		end
		if (start && busy) begin
			start <= 1'b1;
		end else if (queries_waiting.size() != 0 && $urandom_range(99) >= idle_pct) begin
			start <= 1'b1;
			query <= queries_waiting[0];
		end else begin
			start <= 1'b0;
		end
	end

	// monitor: one result per done pulse, checked against the oldest prediction
	always @(posedge clk) begin
		npt_out_t want;
		if (done) begin
			if (nearest_due.size() == 0) begin
				$error("result with no query outstanding");
				n_fail++;
			end else begin
				want = nearest_due.pop_front();
				n_seen++;
				if (want.inside_res) n_inside++;
				if (want.vertex_used) n_vertex++;
				if (result.nearest_x !== want.nearest_x) begin
					$error("nearest_x: expected %0d, got %0d", want.nearest_x, result.nearest_x);
					n_fail++;
				end
				if (result.nearest_y !== want.nearest_y) begin
					$error("nearest_y: expected %0d, got %0d", want.nearest_y, result.nearest_y);
					n_fail++;
				end
				if (result.distance !== want.distance) begin
					$error("distance: expected %0d, got %0d", want.distance, result.distance);
					n_fail++;
				end
				if (result.inside_res !== want.inside_res) begin
					$error("inside_res: expected %0b, got %0b", want.inside_res, result.inside_res);
					n_fail++;
				end
				if (result.vertex_used !== want.vertex_used) begin
					$error("vertex_used: expected %0b, got %0b", want.vertex_used,
						result.vertex_used);
					n_fail++;
				end
			end
		end
	end

	// watchdog: any transfer, config write or reset resets the count
	always @(posedge clk) begin
		if (done || (start && !busy) || cfg_we || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx <= REG_C_Y) begin
			if (idx[0]) tri_y[idx >> 1] = longint'(signed'(val[31:0]));
			else tri_x[idx >> 1] = longint'(signed'(val[31:0]));
		end else if (idx == REG_SIDE_TOL) begin
			side_tol = val;
		end else begin
			edge_lim = val;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_triangle(longint ax, longint ay, longint bx, longint by, longint cx,
		longint cy, logic [62:0] tol, logic [62:0] lim);
		write_reg(REG_A_X, 63'(ax[31:0]));
		write_reg(REG_A_Y, 63'(ay[31:0]));
		write_reg(REG_B_X, 63'(bx[31:0]));
		write_reg(REG_B_Y, 63'(by[31:0]));
		write_reg(REG_C_X, 63'(cx[31:0]));
		write_reg(REG_C_Y, 63'(cy[31:0]));
		write_reg(REG_SIDE_TOL, tol);
		write_reg(REG_SHORT_LIM, lim);
	endtask

	task automatic add_query(longint x, longint y, bit on);
		npt_in_t q;
		q.query_x = x[31:0];
		q.query_y = y[31:0];
		q.on_entity = on;
		queries_waiting.push_back(q);
	endtask

	// let the block drain before the next register write
	task automatic drain();
		while (queries_waiting.size() != 0 || nearest_due.size() != 0 || busy || start)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic longint rand_full();
		return longint'(signed'($urandom()));
	endfunction

	// somewhere around [lo, hi], widened by half the span each side
	function automatic longint rand_near(longint lo, longint hi);
		longint span, v;
		span = hi - lo + 2;
		v = lo - span / 2 + longint'({$urandom(), $urandom()} % (2 * span + 1));
		if (v > C_MAX) v = C_MAX;
		if (v < C_MIN) v = C_MIN;
		return v;
	endfunction

	task automatic random_phase(int n_items);
		longint cx, cy, r, v[6], lox, hix, loy, hiy;
		logic [62:0] tol, lim;
		int shape;
		shape = $urandom_range(9);
		cx = longint'(signed'($urandom())) >>> 8;
		cy = longint'(signed'($urandom())) >>> 8;
		r = (shape < 3) ? 64'd1 << $urandom_range(4, 12) : 64'd1 << $urandom_range(16, 23);
		for (int i = 0; i < 6; i++) begin
			if (shape == 9) v[i] = rand_full();  // full-range triangle
			else v[i] = ((i % 2) ? cy : cx) + longint'($urandom_range(0, 2 * r)) - r;
		end
		if (shape == 8) begin
			// coincident vertices A and B, or B placed straight above A
			v[2] = v[0];
			v[3] = v[1] + (($urandom_range(1)) ? 0 : 64'(r));
		end
		case ($urandom_range(3))
			0: tol = '0;
			1: tol = 63'($urandom_range(0, 1000));
			2: tol = 63'({$urandom(), $urandom()}) >> $urandom_range(20, 62);
			default: tol = '0;
		endcase
		case ($urandom_range(4))
			0: lim = 63'($urandom_range(0, 3));
			1: lim = 63'({$urandom(), $urandom()}) >> $urandom_range(10, 62);
			default: lim = '0;
		endcase
		set_triangle(v[0], v[1], v[2], v[3], v[4], v[5], tol, lim);
		lox = v[0]; hix = v[0]; loy = v[1]; hiy = v[1];
		for (int i = 1; i < 3; i++) begin
			if (v[2*i] < lox) lox = v[2*i];
			if (v[2*i] > hix) hix = v[2*i];
			if (v[2*i+1] < loy) loy = v[2*i+1];
			if (v[2*i+1] > hiy) hiy = v[2*i+1];
		end
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(9) < 2) add_query(rand_full(), rand_full(), $urandom_range(1));
			else add_query(rand_near(lox, hix), rand_near(loy, hiy), $urandom_range(1));
		end
		drain();
	endtask

	initial begin
		automatic int pcts[4] = '{0, 62, 0, 38};
		for (int i = 0; i < 3; i++) begin
			tri_x[i] = 0;
			tri_y[i] = 0;
		end
		side_tol = '0;
		edge_lim = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset triangle is a single point: everything counts as inside
		add_query(5, -7, 1);
		add_query(C_MAX, C_MIN, 0);
		drain();

		// ordinary triangle: inside, beyond each edge, beyond vertices, both flag values
		set_triangle(0, 0, 64'sd655360, 0, 0, 64'sd655360, '0, '0);
		add_query(64'sd65536, 64'sd65536, 0);
		add_query(64'sd300000, -64'sd100000, 0);
		add_query(-64'sd100000, 64'sd300000, 1);
		add_query(64'sd500000, 64'sd500000, 0);
		add_query(64'sd2000000, -64'sd10, 1);
		add_query(64'sd2000000, -64'sd10, 0);
		add_query(-64'sd65536, -64'sd65536, 1);
		add_query(C_MAX, C_MAX, 1);
		add_query(C_MIN, C_MIN, 0);
		add_query(C_MIN, C_MAX, 1);
		add_query(0, 0, 1);
		drain();

		// extreme vertices, projections leave the coordinate range; huge distances
		set_triangle(C_MIN, C_MIN, C_MAX, C_MIN + 1, C_MIN + 3, C_MAX, '0, '0);
		add_query(C_MAX, C_MAX, 0);
		add_query(C_MAX, C_MAX, 1);
		add_query(C_MIN, C_MAX, 0);
		add_query(C_MAX, C_MIN, 0);
		drain();

		// two coincident vertices and every edge declared short
		set_triangle(64'sd1000, 64'sd1000, 64'sd1000, 64'sd1000, 64'sd90000, 0, '0, '1);
		add_query(-64'sd50000, 64'sd70000, 0);
		add_query(64'sd40000, -64'sd60000, 1);
		drain();
		// tolerance at its top: any point is inside
		set_triangle(0, 0, 64'sd655360, 0, 0, 64'sd655360, '1, 63'd0);
		add_query(C_MIN, C_MIN, 1);
		add_query(64'sd9999999, -64'sd3, 0);
		drain();

		for (int p = 0; p < 12; p++) begin
			idle_pct = pcts[p % 4];
			random_phase(155);
		end

		repeat (200) @(posedge clk);
		$display("%0d queries issued, %0d results checked: %0d inside, %0d vertex fallback",
			n_sent, n_seen, n_inside, n_vertex);
		$display("triangles varied from point and collinear to full range, sender gaps 0/38/62%%");
		if (n_fail == 0 && nearest_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/npt_pkg.sv
design/npt_mul.sv
design/npt_div.sv
design/npt_sqrt.sv
design/nearest_point_on_triangle_top.sv
verif/nearest_point_on_triangle_top_tb.sv
